// ===== hdl/bfnc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfnc_pkg
// Shared types, widths and codes for the Bellman-Ford negative cycle block.
// ----------------------------------------------------------------------------
package bfnc_pkg;

   localparam int MAX_NODES  = 64;
   localparam int MAX_EDGES  = 256;
   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int NODE_CNT_W = $clog2(MAX_NODES + 1);
   localparam int EDGE_AW    = $clog2(MAX_EDGES);
   localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
   localparam int COST_W     = 48;
   localparam int DIST_W     = 64;
   localparam int CSR_W      = 7;

   localparam logic signed [DIST_W-1:0] DIST_INF     = 64'sd8000000000000000000;
   localparam logic signed [DIST_W-1:0] DIST_NEG_INF = -64'sd8000000000000000000;

   // Register indexes on the configuration port.
   localparam logic CSR_NUM_NODES   = 1'b0;
   localparam logic CSR_SOURCE_NODE = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_FINITE      = 2'd0;
   localparam logic [1:0] STATUS_UNREACHABLE = 2'd1;
   localparam logic [1:0] STATUS_NEG_INF     = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0]        edge_from;
      logic [NODE_W-1:0]        edge_to;
      logic signed [COST_W-1:0] edge_cost;
      logic                     last_edge;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]        node_index;
      logic [1:0]               node_status;
      logic signed [DIST_W-1:0] distance;
      logic                     last_result;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0]        tail;
      logic [NODE_W-1:0]        head;
      logic signed [COST_W-1:0] weight;
   } edge_type;

   function automatic logic signed [DIST_W-1:0] ext_cost(input logic signed [COST_W-1:0] w);
      ext_cost = {{(DIST_W-COST_W){w[COST_W-1]}}, w};
   endfunction

endpackage

// ===== hdl/bfnc_edge_store.sv =====
// ----------------------------------------------------------------------------
// bfnc_edge_store
// Edge memory: one write port for loading, one registered read port.
// ----------------------------------------------------------------------------
module bfnc_edge_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [bfnc_pkg::EDGE_AW-1:0]  wr_addr,
   input  bfnc_pkg::edge_type            wr_data,
   input  logic [bfnc_pkg::EDGE_AW-1:0]  rd_addr,
   output bfnc_pkg::edge_type            rd_data
);

   bfnc_pkg::edge_type edge_mem [bfnc_pkg::MAX_EDGES];
   bfnc_pkg::edge_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         edge_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= edge_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bellman_ford_negative_cycle.sv =====
// ----------------------------------------------------------------------------
// bellman_ford_negative_cycle
// Loads directed edges, then runs reachability, Bellman-Ford relaxation and
// negative cycle marking, and reports one result per node.
// ----------------------------------------------------------------------------
// Run: an edge without last_edge is only stored. The last edge starts a run of n
// reachability passes, n relaxation passes, one check pass and n marking passes over
// the E stored edges, then the results, for n nodes. One shared 64-bit add and compare
// serves every edge. busy stays high for the whole run; results come one at a time and
// the receiver cannot stall them. Synchronous reset clears the edge count and sets
// num_nodes to 1, source_node to 0.
// ----------------------------------------------------------------------------
module bellman_ford_negative_cycle (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  bfnc_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output bfnc_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [bfnc_pkg::CSR_W-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_EREAD = 3'd2;
   localparam logic [2:0] ST_NREAD = 3'd3;
   localparam logic [2:0] ST_ADD   = 3'd4;
   localparam logic [2:0] ST_CMP   = 3'd5;
   localparam logic [2:0] ST_ORD   = 3'd6;
   localparam logic [2:0] ST_OEMIT = 3'd7;

   localparam logic [1:0] MODE_REACH = 2'd0;
   localparam logic [1:0] MODE_RELAX = 2'd1;
   localparam logic [1:0] MODE_EXTRA = 2'd2;
   localparam logic [1:0] MODE_NEG   = 2'd3;

   localparam int NW  = bfnc_pkg::NODE_W;
   localparam int NCW = bfnc_pkg::NODE_CNT_W;
   localparam int ECW = bfnc_pkg::EDGE_CNT_W;
   localparam int DW  = bfnc_pkg::DIST_W;
   localparam int MN  = bfnc_pkg::MAX_NODES;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             mode_ff, mode_in;
   logic [NCW-1:0]         pass_ff, pass_in;
   logic [ECW-1:0]         edge_ff, edge_in;
   logic [ECW-1:0]         loaded_ff, loaded_in;
   logic [NW-1:0]          node_ff, node_in;
   logic [NCW-1:0]         num_nodes_ff, num_nodes_in;
   logic [NW-1:0]          source_ff, source_in;
   logic [MN-1:0]          reach_ff, reach_in;
   logic [MN-1:0]          neg_ff, neg_in;
   logic [MN-1:0]          dvalid_ff, dvalid_in;
   logic [MN-1:0]          xvalid_ff, xvalid_in;
   logic signed [DW-1:0]   cand_ff, cand_in;
   logic signed [DW-1:0]   dbe_ff, dbe_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   bfnc_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   // Node distance and check-pass copies, with registered reads at two nodes.
   logic signed [DW-1:0]   dist_mem [MN];
   logic signed [DW-1:0]   xdist_mem [MN];
   logic signed [DW-1:0]   da_rd_ff, db_rd_ff, xa_rd_ff, xb_rd_ff;
   logic                   dva_ff, dvb_ff, xva_ff, xvb_ff;

   logic                   dist_we, xdist_we;
   logic [NW-1:0]          dist_waddr;
   logic signed [DW-1:0]   dist_wdata;
   logic [NW-1:0]          rd_a;

   logic                   edge_we;
   bfnc_pkg::edge_type     edge_wdata;
   bfnc_pkg::edge_type     erd;

   logic [NCW-1:0]         n_cnt;
   logic [NCW-1:0]         pass_limit;
   logic                   accept;
   logic                   in_range;
   logic                   step;
   logic signed [DW-1:0]   da_eff, db_eff;
   logic signed [DW-1:0]   sat_val;

   bfnc_edge_store u_edge_store (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (loaded_ff[bfnc_pkg::EDGE_AW-1:0]),
      .wr_data (edge_wdata),
      .rd_addr (edge_ff[bfnc_pkg::EDGE_AW-1:0]),
      .rd_data (erd)
   );

   assign edge_wdata.tail   = req_data.edge_from;
   assign edge_wdata.head   = req_data.edge_to;
   assign edge_wdata.weight = req_data.edge_cost;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Effective node count: zero acts as one, the top is clamped.
   always_comb begin
      if (num_nodes_ff == '0) begin
         n_cnt = NCW'(1);
      end else if (num_nodes_ff > NCW'(MN)) begin
         n_cnt = NCW'(MN);
      end else begin
         n_cnt = num_nodes_ff;
      end
   end

   assign pass_limit = (mode_ff == MODE_EXTRA) ? NCW'(1) : n_cnt;
   assign in_range   = ({1'b0, erd.tail} < n_cnt) && ({1'b0, erd.head} < n_cnt);
   assign rd_a       = (state_ff == ST_ORD) ? node_ff : erd.tail;

   // An entry that was not written this run holds infinity; during the check
   // pass an unwritten copy entry follows the relaxed distance.
   always_comb begin
      logic signed [DW-1:0] dav, dbv;
      dav = dva_ff ? da_rd_ff : bfnc_pkg::DIST_INF;
      dbv = dvb_ff ? db_rd_ff : bfnc_pkg::DIST_INF;
      if (mode_ff == MODE_EXTRA) begin
         da_eff = xva_ff ? xa_rd_ff : dav;
         db_eff = xvb_ff ? xb_rd_ff : dbv;
      end else begin
         da_eff = dav;
         db_eff = dbv;
      end
   end

   assign sat_val = (cand_ff < bfnc_pkg::DIST_NEG_INF) ? bfnc_pkg::DIST_NEG_INF : cand_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      pass_in       = pass_ff;
      edge_in       = edge_ff;
      loaded_in     = loaded_ff;
      node_in       = node_ff;
      num_nodes_in  = num_nodes_ff;
      source_in     = source_ff;
      reach_in      = reach_ff;
      neg_in        = neg_ff;
      dvalid_in     = dvalid_ff;
      xvalid_in     = xvalid_ff;
      cand_in       = cand_ff;
      dbe_in        = dbe_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      dist_we       = 1'b0;
      xdist_we      = 1'b0;
      dist_waddr    = erd.head;
      dist_wdata    = sat_val;
      edge_we       = 1'b0;
      step          = 1'b0;

      if (csr_we) begin
         case (csr_index)
            bfnc_pkg::CSR_NUM_NODES:   num_nodes_in = csr_wdata[NCW-1:0];
            bfnc_pkg::CSR_SOURCE_NODE: source_in    = csr_wdata[NW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Edges beyond the store depth are dropped.
               if (loaded_ff < ECW'(bfnc_pkg::MAX_EDGES)) begin
                  edge_we   = 1'b1;
                  loaded_in = loaded_ff + ECW'(1);
               end
               if (req_data.last_edge) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            reach_in  = '0;
            neg_in    = '0;
            dvalid_in = '0;
            xvalid_in = '0;
            edge_in   = '0;
            pass_in   = '0;
            mode_in   = MODE_REACH;
            if ({1'b0, source_ff} < n_cnt) begin
               reach_in[source_ff]  = 1'b1;
               dvalid_in[source_ff] = 1'b1;
               dist_we              = 1'b1;
               dist_waddr           = source_ff;
               dist_wdata           = '0;
            end
            state_in = ST_EREAD;
         end
         ST_EREAD: begin
            state_in = ST_NREAD;
         end
         ST_NREAD: begin
            case (mode_ff)
               MODE_REACH: begin
                  if (in_range && reach_ff[erd.tail]) begin
                     reach_in[erd.head] = 1'b1;
                  end
                  step = 1'b1;
               end
               MODE_NEG: begin
                  if (in_range && neg_ff[erd.tail]) begin
                     neg_in[erd.head] = 1'b1;
                  end
                  step = 1'b1;
               end
               default: begin
                  if (in_range && reach_ff[erd.head]) begin
                     state_in = ST_ADD;
                  end else begin
                     step = 1'b1;
                  end
               end
            endcase
         end
         ST_ADD: begin
            if (da_eff >= bfnc_pkg::DIST_INF) begin
               step = 1'b1;
            end else begin
               cand_in  = da_eff + bfnc_pkg::ext_cost(erd.weight);
               dbe_in   = db_eff;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (dbe_ff > cand_ff) begin
               if (mode_ff == MODE_RELAX) begin
                  dist_we               = 1'b1;
                  dvalid_in[erd.head]   = 1'b1;
               end else begin
                  xdist_we              = 1'b1;
                  xvalid_in[erd.head]   = 1'b1;
               end
            end
            step = 1'b1;
         end
         ST_ORD: begin
            state_in = ST_OEMIT;
         end
         ST_OEMIT: begin
            rsp_strobe_in          = 1'b1;
            rsp_data_in.node_index = node_ff;
            rsp_data_in.last_result = ({1'b0, node_ff} + NCW'(1) == n_cnt);
            if (!reach_ff[node_ff]) begin
               rsp_data_in.node_status = bfnc_pkg::STATUS_UNREACHABLE;
               rsp_data_in.distance    = '0;
            end else if (neg_ff[node_ff]) begin
               rsp_data_in.node_status = bfnc_pkg::STATUS_NEG_INF;
               rsp_data_in.distance    = '0;
            end else begin
               rsp_data_in.node_status = bfnc_pkg::STATUS_FINITE;
               rsp_data_in.distance    = dva_ff ? da_rd_ff : bfnc_pkg::DIST_INF;
            end
            if ({1'b0, node_ff} + NCW'(1) == n_cnt) begin
               state_in  = ST_IDLE;
               loaded_in = '0;
            end else begin
               node_in  = node_ff + NW'(1);
               state_in = ST_ORD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move to the next edge, the next pass or the next phase of the run.
      if (step) begin
         state_in = ST_EREAD;
         if (edge_ff + ECW'(1) == loaded_ff) begin
            edge_in = '0;
            if (pass_ff + NCW'(1) == pass_limit) begin
               pass_in = '0;
               case (mode_ff)
                  MODE_REACH: mode_in = MODE_RELAX;
                  MODE_RELAX: mode_in = MODE_EXTRA;
                  MODE_EXTRA: begin
                     // A node whose copy still relaxed lies on or behind a
                     // negative cycle.
                     mode_in = MODE_NEG;
                     neg_in  = xvalid_in & reach_ff;
                  end
                  default: begin
                     state_in = ST_ORD;
                     node_in  = '0;
                  end
               endcase
            end else begin
               pass_in = pass_ff + NCW'(1);
            end
         end else begin
            edge_in = edge_ff + ECW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      if (xdist_we) begin
         xdist_mem[erd.head] <= cand_ff;
      end
      da_rd_ff <= dist_mem[rd_a];
      db_rd_ff <= dist_mem[erd.head];
      xa_rd_ff <= xdist_mem[rd_a];
      xb_rd_ff <= xdist_mem[erd.head];
      dva_ff   <= dvalid_ff[rd_a];
      dvb_ff   <= dvalid_ff[erd.head];
      xva_ff   <= xvalid_ff[rd_a];
      xvb_ff   <= xvalid_ff[erd.head];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_REACH;
         pass_ff       <= '0;
         edge_ff       <= '0;
         loaded_ff     <= '0;
         node_ff       <= '0;
         num_nodes_ff  <= NCW'(1);
         source_ff     <= '0;
         reach_ff      <= '0;
         neg_ff        <= '0;
         dvalid_ff     <= '0;
         xvalid_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         pass_ff       <= pass_in;
         edge_ff       <= edge_in;
         loaded_ff     <= loaded_in;
         node_ff       <= node_in;
         num_nodes_ff  <= num_nodes_in;
         source_ff     <= source_in;
         reach_ff      <= reach_in;
         neg_ff        <= neg_in;
         dvalid_ff     <= dvalid_in;
         xvalid_ff     <= xvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      dbe_ff      <= dbe_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
